@@ sv/string_to_integer_parser_assert.svh @@
// ------------------------------------------------------------------------
// string_to_integer_parser assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_ASSERT_SVH

`ifndef SYNTH
// Assertion under reset gating.
`define S2I_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("%m: assertion failed");
// Assertion that also holds during reset.
`define S2I_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("%m: assertion failed");
`else
`define S2I_ASSERT(lbl, clk, rstn, prop)
`define S2I_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ sv/s2i_pkg.sv @@
// ------------------------------------------------------------------------
// s2i_pkg
// Shared types, constants and the character classifier of the parser.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s2i_pkg;

	localparam int POSITION_WIDTH = 16;
	localparam int CH_W           = 16;
	localparam int VALUE_W        = 32;
	localparam int OFFSET_W       = 16;
	localparam int STATUS_W       = 2;
	localparam int BASE_W         = 6;
	localparam int DIGIT_W        = 6;
	localparam int Q_DEPTH        = 2;
	localparam int Q_PTR_W        = $clog2(Q_DEPTH);
	localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

	localparam logic [DIGIT_W-1:0] NOT_DIGIT   = 6'd36;
	localparam logic [DIGIT_W-1:0] ALPHA_FIRST = 6'd10;

	localparam logic [CH_W-1:0] CH_NUL   = 16'h0000;
	localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CH_W-1:0] CH_PLUS  = 16'h002B;
	localparam logic [CH_W-1:0] CH_MINUS = 16'h002D;
	localparam logic [CH_W-1:0] CH_D0    = 16'h0030;
	localparam logic [CH_W-1:0] CH_D9    = 16'h0039;
	localparam logic [CH_W-1:0] CH_UA    = 16'h0041;
	localparam logic [CH_W-1:0] CH_UX    = 16'h0058;
	localparam logic [CH_W-1:0] CH_UZ    = 16'h005A;
	localparam logic [CH_W-1:0] CH_LA    = 16'h0061;
	localparam logic [CH_W-1:0] CH_LX    = 16'h0078;
	localparam logic [CH_W-1:0] CH_LZ    = 16'h007A;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_BAD_BASE  = 2'd2
	} status_t;

	// One classified character with the base register sampled alongside it.
	typedef struct packed {
		logic               term;
		logic               ws;
		logic               plus;
		logic               minus;
		logic               zero;
		logic               hex_x;
		logic [DIGIT_W-1:0] digit;
		logic [BASE_W-1:0]  base;
	} item_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = NOT_DIGIT;
		if (c >= CH_D0 && c <= CH_D9) begin
			d = DIGIT_W'(c - CH_D0);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = DIGIT_W'(c - CH_UA) + ALPHA_FIRST;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = DIGIT_W'(c - CH_LA) + ALPHA_FIRST;
		end
		return d;
	endfunction

	function automatic item_t classify(input logic [CH_W-1:0] c,
		input logic [BASE_W-1:0] b);
		item_t it;
		it.term  = (c == CH_NUL);
		it.ws    = (c == CH_SPACE) || (c == CH_TAB);
		it.plus  = (c == CH_PLUS);
		it.minus = (c == CH_MINUS);
		it.zero  = (c == CH_D0);
		it.hex_x = (c == CH_UX) || (c == CH_LX);
		it.digit = digit_of(c);
		it.base  = b;
		return it;
	endfunction

endpackage

`default_nettype wire

@@ sv/s2i_if.sv @@
// ------------------------------------------------------------------------
// s2i channel interfaces
// Valid/ready channels for characters, results and the base register.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface s2i_char_if;
	logic                    valid;
	logic                    ready;
	logic [s2i_pkg::CH_W-1:0] ch;
	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface s2i_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [s2i_pkg::VALUE_W-1:0] value;
	logic [s2i_pkg::OFFSET_W-1:0]       end_offset;
	logic [s2i_pkg::STATUS_W-1:0]       status;
	modport source (output valid, output value, output end_offset, output status, input ready);
	modport sink   (input valid, input value, input end_offset, input status, output ready);
endinterface

interface s2i_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [s2i_pkg::BASE_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/s2i_front.sv @@
// ------------------------------------------------------------------------
// s2i_front
// Holds the base register, accepts characters and classifies them.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s2i_front (
	input  logic           clk,
	input  logic           arst_n,
	s2i_char_if.sink       chars,
	s2i_cfg_if.sink        cfg,
	output logic           push,
	output s2i_pkg::item_t push_item,
	input  logic           full
);
	import s2i_pkg::*;

	logic [BASE_W-1:0] number_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
		end else if (cfg.valid) begin
			number_base_q <= cfg.data;
		end
	end

	assign cfg.ready   = 1'b1;
	assign chars.ready = !full;
	assign push        = chars.valid && !full;
	// Tag each beat with the current base; the back end keeps it only at string start.
	assign push_item   = classify(chars.ch, number_base_q);

endmodule

`default_nettype wire

@@ sv/s2i_queue.sv @@
// ------------------------------------------------------------------------
// s2i_queue
// Short FIFO of classified characters between front and back end.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s2i_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  s2i_pkg::item_t push_item,
	output logic           full,
	output logic           q_valid,
	output s2i_pkg::item_t q_item,
	input  logic           pop
);
	import s2i_pkg::*;

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/s2i_back.sv @@
// ------------------------------------------------------------------------
// s2i_back
// Parse sequencer: phases, multiply-accumulate with saturation, result.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "string_to_integer_parser_assert.svh"

module s2i_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  s2i_pkg::item_t q_item,
	output logic           pop,
	s2i_result_if.source   result
);
	import s2i_pkg::*;

	typedef enum logic [2:0] {
		PH_START, PH_WS, PH_PREFIX, PH_ZERO, PH_DIGITS, PH_DONE
	} phase_t;

	typedef enum logic {B_EXEC, B_ACC} bstate_t;

	localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
	localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

	bstate_t                   bstate_q;
	phase_t                    phase_q;
	logic                      neg_q;
	logic                      any_q;
	logic [VALUE_W-1:0]        acc_q;
	logic [BASE_W-1:0]         base_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] stop_q;
	logic signed [38:0]        prod_s1;
	logic [DIGIT_W-1:0]        digit_s1;
	logic                      out_valid_q;
	logic [VALUE_W-1:0]        value_q;
	logic [OFFSET_W-1:0]       offset_q;
	status_t                   status_q;

	logic                      slot_free;
	logic [BASE_W-1:0]         base_e;
	logic                      base_ok;
	phase_t                    phase_e;
	phase_t                    phase_n;
	logic                      neg_n;
	logic                      any_n;
	logic [BASE_W-1:0]         base_n;
	logic [POSITION_WIDTH-1:0] stop_n;
	logic                      enter_num;
	logic                      try_digit;
	logic                      take;
	status_t                   status_n;
	logic [VALUE_W-1:0]        value_n;
	logic [OFFSET_W-1:0]       offset_n;
	logic signed [39:0]        sum;
	logic [VALUE_W-1:0]        acc_sat;

	assign slot_free = !out_valid_q || result.ready;
	assign pop       = (bstate_q == B_EXEC) && q_valid && (!q_item.term || slot_free);

	// Sample the base on the first beat of a string.
	assign base_e  = (phase_q == PH_START) ? q_item.base : base_q;
	assign base_ok = (base_e != BASE_ONE) && (base_e <= BASE_MAX);
	assign phase_e = (phase_q == PH_START) ? (base_ok ? PH_WS : PH_DONE) : phase_q;

	always_comb begin
		phase_n   = phase_e;
		neg_n     = neg_q;
		any_n     = any_q;
		base_n    = base_e;
		stop_n    = stop_q;
		enter_num = 1'b0;
		try_digit = 1'b0;
		take      = 1'b0;
		unique case (phase_e)
			PH_WS: begin
				if (q_item.ws) begin
					phase_n = PH_WS;
				end else if (q_item.plus || q_item.minus) begin
					neg_n   = q_item.minus;
					phase_n = PH_PREFIX;
				end else begin
					enter_num = 1'b1;
				end
			end
			PH_PREFIX: begin
				enter_num = 1'b1;
			end
			PH_ZERO: begin
				phase_n = PH_DIGITS;
				if (q_item.hex_x) begin
					base_n = BASE_HEX;
				end else begin
					// The pending leading zero counts as a digit.
					base_n    = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
					any_n     = 1'b1;
					stop_n    = pos_q;
					try_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				try_digit = 1'b1;
			end
			default: begin
				phase_n = phase_e;
			end
		endcase
		if (enter_num) begin
			if (q_item.zero && (base_e == BASE_AUTO || base_e == BASE_HEX)) begin
				phase_n = PH_ZERO;
			end else begin
				base_n    = (base_e == BASE_AUTO) ? BASE_DEC : base_e;
				phase_n   = PH_DIGITS;
				try_digit = 1'b1;
			end
		end
		if (try_digit) begin
			if (q_item.digit < base_n) begin
				take   = 1'b1;
				any_n  = 1'b1;
				stop_n = pos_q + 1'b1;
			end else begin
				phase_n = PH_DONE;
			end
		end
		if (q_item.term) begin
			take = 1'b0;
		end
	end

	// Terminator result; a pending leading zero is a complete number.
	always_comb begin
		if (!base_ok) begin
			status_n = ST_BAD_BASE;
		end else if (any_q || phase_e == PH_ZERO) begin
			status_n = ST_OK;
		end else begin
			status_n = ST_NO_DIGITS;
		end
		value_n  = (status_n == ST_OK) ? acc_q : '0;
		offset_n = '0;
		if (status_n == ST_OK) begin
			offset_n = OFFSET_W'((phase_e == PH_ZERO) ? pos_q : stop_q);
		end
	end

	always_comb begin
		if (neg_q) begin
			sum = $signed({prod_s1[38], prod_s1}) - $signed({34'd0, digit_s1});
		end else begin
			sum = $signed({prod_s1[38], prod_s1}) + $signed({34'd0, digit_s1});
		end
		if (sum > SAT_MAX) begin
			acc_sat = VALUE_W'(SAT_MAX);
		end else if (sum < SAT_MIN) begin
			acc_sat = VALUE_W'(SAT_MIN);
		end else begin
			acc_sat = VALUE_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= B_EXEC;
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			any_q       <= 1'b0;
			acc_q       <= '0;
			base_q      <= '0;
			pos_q       <= '0;
			stop_q      <= '0;
			prod_s1     <= '0;
			digit_s1    <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			offset_q    <= '0;
			status_q    <= ST_OK;
		end else begin
			if (out_valid_q && result.ready && !(pop && q_item.term)) begin
				out_valid_q <= 1'b0;
			end
			unique case (bstate_q)
				B_EXEC: begin
					if (pop && q_item.term) begin
						out_valid_q <= 1'b1;
						value_q     <= value_n;
						offset_q    <= offset_n;
						status_q    <= status_n;
						phase_q     <= PH_START;
						neg_q       <= 1'b0;
						any_q       <= 1'b0;
						acc_q       <= '0;
						base_q      <= '0;
						pos_q       <= '0;
						stop_q      <= '0;
					end else if (pop) begin
						phase_q <= phase_n;
						neg_q   <= neg_n;
						any_q   <= any_n;
						base_q  <= base_n;
						stop_q  <= stop_n;
						pos_q   <= pos_q + 1'b1;
						if (take) begin
							prod_s1  <= 39'($signed(acc_q)) * 39'($signed({1'b0, base_n}));
							digit_s1 <= q_item.digit;
							bstate_q <= B_ACC;
						end
					end
				end
				B_ACC: begin
					acc_q    <= acc_sat;
					bstate_q <= B_EXEC;
				end
				default: begin
					bstate_q <= B_EXEC;
				end
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.value      = value_q;
	assign result.end_offset = offset_q;
	assign result.status     = status_q;

	`S2I_ASSERT(a_acc_follows_pop, clk, arst_n, (bstate_q == B_ACC) |-> $past(pop))
	`S2I_ASSERT(a_term_clears, clk, arst_n, (pop && q_item.term) |=> (phase_q == PH_START && pos_q == '0 && !any_q))
	`S2I_ASSERT(a_neg_sign, clk, arst_n, (bstate_q == B_ACC && neg_q) |=> (acc_q[VALUE_W-1] || acc_q == '0))
	`S2I_ASSERT(a_pos_sign, clk, arst_n, (bstate_q == B_ACC && !neg_q) |=> !acc_q[VALUE_W-1])
	`S2I_ASSERT_ALWAYS(a_no_result_in_reset, clk, !arst_n |-> !out_valid_q)

endmodule

`default_nettype wire

@@ sv/string_to_integer_parser.sv @@
// ------------------------------------------------------------------------
// string_to_integer_parser
// Streaming saturating string-to-integer parser, one character per beat.
// ------------------------------------------------------------------------
//
//   channel  dir  payload                         beat means
//   chars    in   ch[15:0]                        one character, 0 ends string
//   result   out  value[31:0] end_offset status   one parsed number
//   cfg      in   data[5:0]                       write of the base register
//
// The front end classifies a character in the cycle it is accepted and
// pushes it into a two-entry queue, so chars.ready only drops when the
// queue is full. The back end takes a character with no digit in its exec
// state; a digit adds the accumulate state: multiply in exec, then add and
// saturation, a dependency on the previous accumulator that sets the rate.
// A terminator waits in the queue while the result register still holds an
// untaken beat. Reset clears all parse state at once; the base returns to 10.
//
`timescale 1ns / 1ps
`default_nettype none

module string_to_integer_parser (
	input  logic         clk,
	input  logic         arst_n,
	s2i_char_if.sink     chars,
	s2i_result_if.source result,
	s2i_cfg_if.sink      cfg
);
	import s2i_pkg::*;

	// front to queue
	logic  push;
	item_t push_item;
	logic  full;

	// queue to back end
	logic  q_valid;
	item_t q_item;
	logic  pop;

	// Classify and tag characters with the current base.
	s2i_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg       (cfg),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	// Decouple acceptance from the multi-cycle back end.
	s2i_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	// Run the parse phases and hold the result beat.
	s2i_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

@@ tb/sv/s2i_number_checker.sv @@
// ------------------------------------------------------------------------
// s2i_number_checker
// Watches the character, result and base channels of the parser, predicts
// each parsed number and compares it field by field with the result beats.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2i_number_checker (
	input  logic        clk,
	input  logic        arst_n,
	s2i_char_if         chars,
	s2i_result_if       result,
	s2i_cfg_if          cfg,
	output int unsigned err_count,
	output int unsigned pending
);
	import s2i_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_WS,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} parse_phase_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [OFFSET_W-1:0]       end_offset;
		status_t                   status;
	} number_t;

	localparam logic [CH_W-1:0] CASE_BIT = 16'h0020;
	localparam longint          SAT_MAX  = 64'sd2147483647;
	localparam longint          SAT_MIN  = -64'sd2147483648;

	number_t expected_numbers[$];
	int unsigned mismatch_total;

	// Predicted parser state
	logic [BASE_W-1:0]         base_reg;
	parse_phase_t              phase;
	logic                      neg;
	logic                      seen_digit;
	logic signed [VALUE_W-1:0] acc;
	logic [BASE_W-1:0]         base_act;
	logic [POSITION_WIDTH-1:0] pos;
	logic [POSITION_WIDTH-1:0] stop;

	function automatic logic base_valid(input logic [BASE_W-1:0] b);
		return (b != BASE_ONE) && (b <= BASE_MAX);
	endfunction

	// Fold upper case onto lower case for the letter test.
	function automatic logic [DIGIT_W-1:0] char_value(input logic [CH_W-1:0] c);
		logic [CH_W-1:0] folded;
		folded = c | CASE_BIT;
		if (c >= CH_D0 && c <= CH_D9) begin
			return DIGIT_W'(c - CH_D0);
		end
		if (folded >= CH_LA && folded <= CH_LZ) begin
			return DIGIT_W'(folded - CH_LA) + ALPHA_FIRST;
		end
		return NOT_DIGIT;
	endfunction

	function automatic void clear_string();
		phase      = PH_START;
		neg        = 1'b0;
		seen_digit = 1'b0;
		acc        = '0;
		base_act   = '0;
		pos        = '0;
		stop       = '0;
	endfunction

	function automatic bit accum_digit(input logic [DIGIT_W-1:0] v,
		input logic [POSITION_WIDTH-1:0] at);
		longint sum;
		if (v >= base_act) begin
			return 1'b0;
		end
		sum = longint'(acc) * longint'(base_act);
		sum = neg ? sum - longint'(v) : sum + longint'(v);
		if (sum > SAT_MAX) sum = SAT_MAX;
		if (sum < SAT_MIN) sum = SAT_MIN;
		acc        = sum[VALUE_W-1:0];
		seen_digit = 1'b1;
		stop       = at;
		return 1'b1;
	endfunction

	function automatic void digit_step(input logic [CH_W-1:0] c);
		if (!accum_digit(char_value(c), pos + 1'b1)) begin
			phase = PH_DONE;
		end
	endfunction

	function automatic void first_char(input logic [CH_W-1:0] c);
		if (c == CH_D0 && (base_act == BASE_AUTO || base_act == BASE_HEX)) begin
			phase = PH_ZERO;
		end else begin
			if (base_act == BASE_AUTO) base_act = BASE_DEC;
			phase = PH_DIGITS;
			digit_step(c);
		end
	endfunction

	function automatic void parse_char(input logic [CH_W-1:0] c);
		number_t n;
		if (phase == PH_START) begin
			base_act = base_reg;
			phase    = base_valid(base_act) ? PH_WS : PH_DONE;
		end
		if (c == CH_NUL) begin
			if (!base_valid(base_act)) begin
				n.status = ST_BAD_BASE;
			end else begin
				// a lone leading zero is a digit of its own
				if (phase == PH_ZERO) begin
					if (base_act == BASE_AUTO) base_act = BASE_OCT;
					void'(accum_digit('0, pos));
				end
				n.status = seen_digit ? ST_OK : ST_NO_DIGITS;
			end
			n.value      = (n.status == ST_OK) ? acc : '0;
			n.end_offset = (n.status == ST_OK) ? OFFSET_W'(stop) : '0;
			expected_numbers.push_back(n);
			clear_string();
		end else begin
			case (phase)
				PH_WS: begin
					if (c == CH_MINUS || c == CH_PLUS) begin
						neg   = (c == CH_MINUS);
						phase = PH_PREFIX;
					end else if (c != CH_SPACE && c != CH_TAB) begin
						first_char(c);
					end
				end
				PH_PREFIX: first_char(c);
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						base_act = BASE_HEX;
						phase    = PH_DIGITS;
					end else begin
						if (base_act == BASE_AUTO) base_act = BASE_OCT;
						void'(accum_digit('0, pos));
						phase = PH_DIGITS;
						digit_step(c);
					end
				end
				PH_DIGITS: digit_step(c);
				default: ;
			endcase
			pos = pos + 1'b1;
		end
	endfunction

	function automatic void check_result();
		number_t want;
		if (expected_numbers.size() == 0) begin
			$error("unexpected result: value %0d end_offset %0d status %0d",
				result.value, result.end_offset, result.status);
			mismatch_total++;
		end else begin
			want = expected_numbers.pop_front();
			if (result.value !== want.value) begin
				$error("value: expected %0d, got %0d", want.value, result.value);
				mismatch_total++;
			end
			if (result.end_offset !== want.end_offset) begin
				$error("end_offset: expected %0d, got %0d", want.end_offset,
					result.end_offset);
				mismatch_total++;
			end
			if (result.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, result.status);
				mismatch_total++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = BASE_RESET;
			clear_string();
			expected_numbers.delete();
			mismatch_total = 0;
			pending   <= 0;
			err_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) base_reg = cfg.data;
			if (chars.valid && chars.ready) parse_char(chars.ch);
			if (result.valid && result.ready) check_result();
			pending   <= expected_numbers.size();
			err_count <= mismatch_total;
		end
	end

endmodule

@@ tb/sv/tb_string_to_integer_parser.sv @@
// ------------------------------------------------------------------------
// tb_string_to_integer_parser
// Drives strings into the parser under several number bases: a directed
// set of edge cases first, then random numbers and noise, with random
// sender gaps and receiver stalls. A checker beside the block predicts and
// compares every result; the verdict comes from its failure count.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_string_to_integer_parser;
	import s2i_pkg::*;

	localparam int              CLK_HALF    = 6;
	localparam int              RESET_TICKS = 8;
	localparam int              IDLE_TICKS  = 16;
	localparam int              CYCLE_LIMIT = 3000000;
	localparam int              RAND_ITEMS  = 1600;
	localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
	localparam logic [BASE_W-1:0] BASE_TOP  = 6'd63;
	localparam logic [BASE_W-1:0] BASE_OVER = 6'd37;

	logic clk;
	logic arst_n;

	s2i_char_if   chars_if ();
	s2i_result_if result_if ();
	s2i_cfg_if    cfg_if ();

	int unsigned err_count;
	int unsigned pending;

	// Sender and receiver pacing
	int          gap_max;
	int          burst_left;
	int          stall_mode;
	int          stall_left;
	int unsigned chars_sent;
	int unsigned cycle_count;

	string_to_integer_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	s2i_number_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars_if),
		.result    (result_if),
		.cfg       (cfg_if),
		.err_count (err_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Receiver: stall_mode 0 takes every beat, 1 drops ready in short
	// bursts, 2 holds it low for long stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left      <= 0;
		end else if (stall_left != 0) begin
			result_if.ready <= 1'b0;
			stall_left      <= stall_left - 1;
		end else begin
			result_if.ready <= 1'b1;
			case (stall_mode)
				1: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
				2: if ($urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 40);
				default: ;
			endcase
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Send one character beat. Call at a rising edge; return at the edge
	// where the beat was taken. Insert a random gap between bursts.
	task automatic send_char(input logic [CH_W-1:0] c);
		if (gap_max != 0 && burst_left == 0) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		chars_if.valid <= 1'b1;
		chars_if.ch    <= c;
		@(posedge clk);
		while (!chars_if.ready) @(posedge clk);
		if (burst_left != 0) burst_left--;
		chars_sent++;
	endtask

	// Send a literal string followed by the terminator.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(CH_W'(s[i]));
		end
		send_char(CH_NUL);
	endtask

	// Drop valid and wait until every predicted number has come back, then
	// let the back end settle before touching the base register.
	task automatic drain();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_TICKS) @(posedge clk);
	endtask

	task automatic write_base(input logic [BASE_W-1:0] b);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= b;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [CH_W-1:0] digit_char(input int d);
		if (d < 10) begin
			return CH_D0 + CH_W'(d);
		end
		return ($urandom_range(0, 1) ? CH_UA : CH_LA) + CH_W'(d - 10);
	endfunction

	// Mostly characters the parser cares about, otherwise any nonzero code.
	function automatic logic [CH_W-1:0] any_char();
		case ($urandom_range(0, 9))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_PLUS;
			3: return CH_MINUS;
			4: return CH_D0;
			5: return $urandom_range(0, 1) ? CH_LX : CH_UX;
			6: return digit_char($urandom_range(0, 35));
			default: return CH_W'($urandom_range(1, 16'hFFFF));
		endcase
	endfunction

	// Well-formed number: blanks, sign, prefix, digits of the base, then
	// optional trailing junk and the terminator.
	task automatic add_number(input logic [BASE_W-1:0] b);
		int radix;
		int n;
		radix = (b == BASE_AUTO || b == BASE_ONE || b > BASE_MAX) ? 10 : int'(b);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) send_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		end
		case ($urandom_range(0, 3))
			0: send_char(CH_MINUS);
			1: send_char(CH_PLUS);
			default: ;
		endcase
		if (b == BASE_AUTO || b == BASE_HEX) begin
			case ($urandom_range(0, 2))
				0: begin
					send_char(CH_D0);
					send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
					radix = 16;
				end
				1: begin
					send_char(CH_D0);
					radix = (b == BASE_AUTO) ? 8 : 16;
				end
				default: ;
			endcase
		end
		// long runs push the value into saturation
		n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
		repeat (n) send_char(digit_char($urandom_range(0, radix - 1)));
		case ($urandom_range(0, 3))
			0: send_char(any_char());
			1: repeat ($urandom_range(1, 4)) send_char(any_char());
			default: ;
		endcase
		send_char(CH_NUL);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(0, 12)) send_char(any_char());
		send_char(CH_NUL);
	endtask

	function automatic logic [BASE_W-1:0] pick_base();
		case ($urandom_range(0, 13))
			0, 1: return BASE_AUTO;
			2, 3: return BASE_HEX;
			4:    return BASE_DEC;
			5:    return BASE_OCT;
			6:    return BASE_BIN;
			7:    return BASE_MAX;
			8:    return BASE_ONE;
			9:    return BASE_W'($urandom_range(37, 63));
			default: return BASE_W'($urandom_range(2, 36));
		endcase
	endfunction

	initial begin
		logic [BASE_W-1:0] base;

		// Hold the reset, character and base inputs at a known value from time zero.
		arst_n          = 1'b0;
		chars_if.valid  = 1'b0;
		chars_if.ch     = CH_NUL;
		cfg_if.valid    = 1'b0;
		cfg_if.data     = BASE_RESET;
		gap_max         = 0;
		burst_left      = 0;
		stall_mode      = 0;
		chars_sent      = 0;

		repeat (RESET_TICKS) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset base of 10 first, no write yet.
		send_text("");
		send_text(" \t-123");
		send_text("+2147483647");
		send_text("2147483648");
		send_text("-2147483648");
		send_text("-99999999999");
		send_text("+");
		send_text("12a7");
		drain();

		// Auto-detect: hex prefix, bare prefix, octal, lone zero.
		stall_mode <= 1;
		gap_max = 3;
		write_base(BASE_AUTO);
		send_text("0x1F");
		send_text("-0X");
		send_text("017");
		send_text("0");
		send_text("  -0x7fffffff");
		send_text("08");
		drain();

		write_base(BASE_HEX);
		send_text("0xff");
		send_text("FfG");
		send_text("0x");
		send_text("0");
		drain();

		stall_mode <= 2;
		write_base(BASE_MAX);
		send_text("-Zz9");
		drain();

		write_base(BASE_BIN);
		send_text("1012");
		drain();

		// Invalid bases ignore everything up to the terminator.
		write_base(BASE_ONE);
		send_text("12");
		drain();
		write_base(BASE_TOP);
		send_text("7");
		drain();
		write_base(BASE_OVER);
		send_text("x");
		drain();

		// Random phases: new base, new pacing, a batch of strings.
		while (chars_sent < RAND_ITEMS) begin
			base = pick_base();
			write_base(base);
			case ($urandom_range(0, 2))
				0: gap_max = 0;
				1: gap_max = 2;
				default: gap_max = 8;
			endcase
			burst_left = 0;
			stall_mode <= $urandom_range(0, 2);
			repeat ($urandom_range(4, 16)) begin
				if ($urandom_range(0, 4) == 0) add_noise();
				else add_number(base);
			end
			drain();
		end

		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/s2i_pkg.sv
sv/s2i_if.sv
sv/s2i_front.sv
sv/s2i_queue.sv
sv/s2i_back.sv
sv/string_to_integer_parser.sv
tb/sv/s2i_number_checker.sv
tb/sv/tb_string_to_integer_parser.sv
